FILE: hdl/mdir_pkg.sv
// ----------------------------------------------------------------------------
// mdir_pkg
// Shared types and constants for the MESI direct-mapped cache directory.
// ----------------------------------------------------------------------------
package mdir_pkg;

  // Default geometry of the directory.
  localparam int unsigned DefNumLines = 256;
  localparam int unsigned DefTagBits  = 20;

  // Fixed widths of the request and result fields on the stream ports.
  localparam int unsigned TypeFieldW  = 2;
  localparam int unsigned TagFieldW   = 20;
  localparam int unsigned IndexFieldW = 8;
  localparam int unsigned StateFieldW = 2;

  // Packed widths of the stream payloads, rounded up to whole bytes.
  localparam int unsigned ReqBits  = TypeFieldW + TagFieldW + IndexFieldW;
  localparam int unsigned ReqDataW = ((ReqBits + 7) / 8) * 8;
  localparam int unsigned RspBits  = 1 + 1 + TagFieldW + 1 + StateFieldW + TagFieldW;
  localparam int unsigned RspDataW = ((RspBits + 7) / 8) * 8;

  // Request kinds.
  typedef enum logic [TypeFieldW-1:0] {
    REQ_LOCAL_READ   = 2'd0,
    REQ_LOCAL_WRITE  = 2'd1,
    REQ_REMOTE_READ  = 2'd2,
    REQ_REMOTE_WRITE = 2'd3
  } req_e;

  // MESI line states, as stored and as reported.
  typedef enum logic [StateFieldW-1:0] {
    MESI_I = 2'd0,
    MESI_S = 2'd1,
    MESI_E = 2'd2,
    MESI_M = 2'd3
  } mesi_e;

  // Flags produced by the state update for one request.
  typedef struct packed {
    logic hit;
    logic wb_req;
    logic mem_inval;
  } upd_flags_t;

endpackage

FILE: hdl/mdir_line_ram.sv
// ----------------------------------------------------------------------------
// mdir_line_ram
// Single-port-write, single-port-read line store with a registered read.
// ----------------------------------------------------------------------------
module mdir_line_ram
  import mdir_pkg::*;
#(
  parameter int unsigned Width = DefTagBits + StateFieldW,
  parameter int unsigned Depth = DefNumLines
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read before write: a read at the same edge as a write sees the old entry.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/mdir_next_state.sv
// ----------------------------------------------------------------------------
// mdir_next_state
// MESI transition and victim logic for one line and one request.
// ----------------------------------------------------------------------------
module mdir_next_state
  import mdir_pkg::*;
#(
  parameter int unsigned TagBits = DefTagBits
) (
  input  req_e               req_type_i,
  input  logic [TagBits-1:0] req_tag_i,
  input  logic [TagBits-1:0] cur_tag_i,
  input  mesi_e              cur_state_i,
  output logic [TagBits-1:0] new_tag_o,
  output mesi_e              new_state_o,
  output logic [TagBits-1:0] wb_tag_o,
  output upd_flags_t         flags_o
);

  logic hit;

  assign hit = (cur_tag_i == req_tag_i) && (cur_state_i != MESI_I);

  always_comb begin
    new_tag_o         = cur_tag_i;
    new_state_o       = cur_state_i;
    wb_tag_o          = '0;
    flags_o.hit       = hit;
    flags_o.wb_req    = 1'b0;
    flags_o.mem_inval = 1'b0;
    unique case (req_type_i) inside
      REQ_LOCAL_READ, REQ_LOCAL_WRITE: begin
        // A local miss refills the line; a Modified victim is written back.
        if (!hit) begin
          if (cur_state_i == MESI_M) begin
            flags_o.wb_req = 1'b1;
            wb_tag_o       = cur_tag_i;
          end
          new_tag_o   = req_tag_i;
          new_state_o = MESI_S;
        end
        if (req_type_i == REQ_LOCAL_WRITE) begin
          new_state_o       = MESI_M;
          flags_o.mem_inval = 1'b1;
        end
      end
      REQ_REMOTE_READ: begin
        if (hit) begin
          new_state_o = MESI_S;
        end
      end
      REQ_REMOTE_WRITE: begin
        if (hit) begin
          new_state_o = MESI_I;
        end
      end
      default: begin
        new_state_o = cur_state_i;
      end
    endcase
  end

endmodule

FILE: hdl/mesi_direct_mapped_cache_directory.sv
// ----------------------------------------------------------------------------
// mesi_direct_mapped_cache_directory
// Direct-mapped directory holding a tag and a MESI state for every line.
// ----------------------------------------------------------------------------
// Each request on the slave stream is a local read, local write, remote read
// or remote write for one line; each produces exactly one response on the
// master stream with the hit flag, any Modified victim to write back, the
// memory invalidate flag and the tag and state the line holds afterwards.
// After reset the block sweeps the whole line store to Invalid, one line per
// cycle, and takes no request until the sweep is done. From then on a request
// passes through the store read, then the update and write back, and one
// request can be taken every cycle while the response stream does not stall:
// the single store read port sets that rate, and a request to the line that
// the previous one is just writing is served from a bypass register. Line
// indices beyond the store wrap modulo NUM_LINES, and only the low TAG_BITS
// bits of a tag are kept and compared.
// ----------------------------------------------------------------------------
module mesi_direct_mapped_cache_directory
  import mdir_pkg::*;
#(
  parameter int unsigned NUM_LINES = DefNumLines,
  parameter int unsigned TAG_BITS  = DefTagBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request stream.
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [1:0] req_type, [21:2] tag, [29:22] line_index, [31:30] zero.
  input  logic [ReqDataW-1:0] s_axis_tdata_i,
  // Response stream.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] hit, [1] writeback_req, [21:2] writeback_tag, [22] mem_invalidate,
  // [24:23] line_state, [44:25] line_tag, [47:45] zero.
  output logic [RspDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned IdxW = $clog2(NUM_LINES);
  localparam int unsigned EntW = TAG_BITS + StateFieldW;

  // Fields of an incoming request.
  req_e                   in_type;
  logic [TagFieldW-1:0]   in_tag_raw;
  logic [IndexFieldW-1:0] in_line;
  logic [TAG_BITS-1:0]    in_tag;
  logic [IdxW-1:0]        in_idx;
  logic                   in_fire;

  assign in_type    = req_e'(s_axis_tdata_i[TypeFieldW-1:0]);
  assign in_tag_raw = s_axis_tdata_i[TypeFieldW +: TagFieldW];
  assign in_line    = s_axis_tdata_i[TypeFieldW + TagFieldW +: IndexFieldW];

  // Keep only the tag bits that the store holds.
  if (TAG_BITS <= TagFieldW) begin : g_tag_narrow
    assign in_tag = in_tag_raw[TAG_BITS-1:0];
  end else begin : g_tag_wide
    assign in_tag = {{(TAG_BITS - TagFieldW){1'b0}}, in_tag_raw};
  end

  // Wrap the line index into the store by conditional subtraction of shifted
  // copies of the line count, from the largest multiple down.
  always_comb begin
    logic [IndexFieldW-1:0] rem;
    rem = in_line;
    for (int k = IndexFieldW - 1; k >= 0; k--) begin
      if ((64'(NUM_LINES) << k) < 64'(1 << IndexFieldW)) begin
        if (64'(rem) >= (64'(NUM_LINES) << k)) begin
          rem = rem - IndexFieldW'(64'(NUM_LINES) << k);
        end
      end
    end
    in_idx = IdxW'(rem);
  end

  // Clearing sweep after reset.
  logic            clr_busy_q, clr_busy_d;
  logic [IdxW-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + IdxW'(1);
      if (clr_cnt_q == IdxW'(NUM_LINES - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // Update stage: the request whose line entry is being read this cycle.
  logic                s1_vld_q;
  req_e                s1_type_q;
  logic [TAG_BITS-1:0] s1_tag_q;
  logic [IdxW-1:0]     s1_idx_q;
  logic                byp_vld_q;
  logic [EntW-1:0]     byp_ent_q;
  logic                s1_adv;

  // Response register.
  logic                out_vld_q;
  logic [RspDataW-1:0] out_data_q;

  assign s1_adv          = s1_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !clr_busy_q && (!s1_vld_q || s1_adv);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Line store.
  logic [EntW-1:0] rd_ent;
  logic [EntW-1:0] cur_ent;
  logic [EntW-1:0] upd_ent;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [EntW-1:0] ram_wdata;

  assign ram_we    = clr_busy_q || s1_adv;
  assign ram_waddr = clr_busy_q ? clr_cnt_q : s1_idx_q;
  assign ram_wdata = clr_busy_q ? {MESI_I, {TAG_BITS{1'b0}}} : upd_ent;

  mdir_line_ram #(
    .Width (EntW),
    .Depth (NUM_LINES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_idx),
    .rdata_o (rd_ent)
  );

  // The store returns the old entry when the previous request writes the
  // same line at the read edge, so that entry is taken from the bypass.
  assign cur_ent = byp_vld_q ? byp_ent_q : rd_ent;

  logic [TAG_BITS-1:0] new_tag;
  mesi_e               new_state;
  logic [TAG_BITS-1:0] wb_tag;
  upd_flags_t          flags;

  mdir_next_state #(
    .TagBits (TAG_BITS)
  ) u_next_state (
    .req_type_i  (s1_type_q),
    .req_tag_i   (s1_tag_q),
    .cur_tag_i   (cur_ent[TAG_BITS-1:0]),
    .cur_state_i (mesi_e'(cur_ent[EntW-1 -: StateFieldW])),
    .new_tag_o   (new_tag),
    .new_state_o (new_state),
    .wb_tag_o    (wb_tag),
    .flags_o     (flags)
  );

  assign upd_ent = {new_state, new_tag};

  // Tags on the response stream are the low field-width bits of the store.
  logic [TagFieldW-1:0] out_wb_tag;
  logic [TagFieldW-1:0] out_line_tag;

  if (TAG_BITS >= TagFieldW) begin : g_out_tag_wide
    assign out_wb_tag   = wb_tag[TagFieldW-1:0];
    assign out_line_tag = new_tag[TagFieldW-1:0];
  end else begin : g_out_tag_narrow
    assign out_wb_tag   = {{(TagFieldW - TAG_BITS){1'b0}}, wb_tag};
    assign out_line_tag = {{(TagFieldW - TAG_BITS){1'b0}}, new_tag};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      byp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_q  <= 1'b1;
        byp_vld_q <= s1_adv && (s1_idx_q == in_idx);
      end else if (s1_adv) begin
        s1_vld_q  <= 1'b0;
        byp_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_type_q <= in_type;
      s1_tag_q  <= in_tag;
      s1_idx_q  <= in_idx;
      byp_ent_q <= upd_ent;
    end
    if (s1_adv) begin
      out_data_q <= RspDataW'({out_line_tag, new_state, flags.mem_inval,
                               out_wb_tag, flags.wb_req, flags.hit});
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
